// File: rtl/mmcd_pkg.sv
// ----------------------------------------------------------------------------
// Min/max column decimator package
// Item types, register indexes and widths shared by the decimator RTL.
// ----------------------------------------------------------------------------
package mmcd_pkg;

  localparam int SAMPLE_INDEX_W = 24;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int PANE_W         = 12;
  localparam int ROW_CLIP_W     = 13;

  localparam logic [CFG_INDEX_W-1:0] CFG_X_RESOLUTION    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE_Y_MAX = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_SCALE         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_STEP     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PANE_LEFT       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_PANE_TOP        = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_PANE_WIDTH      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_PANE_HEIGHT     = 3'd7;

  typedef struct packed {
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic               series_start;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]           screen_column;
    logic signed [31:0]           row_from;
    logic signed [31:0]           row_to;
    logic [ROW_CLIP_W-1:0]        clipped_top;
    logic [ROW_CLIP_W-1:0]        clipped_bottom;
    logic                         has_visible;
    logic                         out_of_bounds;
    logic [31:0]                  span_rows;
  } out_item_t;

endpackage

// File: rtl/min_max_column_decimator.sv
// ----------------------------------------------------------------------------
// Min/max column decimator
// A closing sample's span passes through the s1, s2, s3 and output registers before out_valid.
// Throughput: one sample per cycle unless out_ready back-pressure fills the pipeline and drops in_ready.
// The span path is a four-stage pipeline (difference, 32x32 multiply, row, clip).
// Reset: synchronous active-low rst_n restores the register defaults and an open
// window at x = 0, y = 0 with sample index 0; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module min_max_column_decimator
  import mmcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [SAMPLE_INDEX_W-1:0] INDEX_LAST = '1;

  // Configuration registers.
  logic [30:0]        x_resolution_r;
  logic signed [31:0] reference_y_max_r;
  logic [31:0]        y_scale_r;
  logic [31:0]        column_step_r;
  logic [PANE_W-1:0]  pane_left_r;
  logic [PANE_W-1:0]  pane_top_r;
  logic [PANE_W-1:0]  pane_width_r;
  logic [PANE_W-1:0]  pane_height_r;

  // Window state.
  logic signed [31:0]        window_start_x_r;
  logic signed [31:0]        window_min_y_r;
  logic signed [31:0]        window_max_y_r;
  logic [SAMPLE_INDEX_W-1:0] sample_index_r;
  logic [30:0]               column_pixel_r;
  logic [30:0]               column_pixel_nxt;

  // Pipeline registers.
  logic               s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic               s1_neg_hi_r, s1_neg_lo_r;
  logic [31:0]        s1_mag_hi_r, s1_mag_lo_r;
  logic signed [31:0] s1_screen_r;
  logic               s1_col_ok_r;
  logic               s2_neg_hi_r, s2_neg_lo_r;
  logic [63:0]        s2_prod_hi_r, s2_prod_lo_r;
  logic signed [31:0] s2_screen_r;
  logic               s2_col_ok_r;
  logic signed [31:0] s3_row_from_r, s3_row_to_r;
  logic signed [31:0] s3_screen_r;
  logic               s3_col_ok_r;
  out_item_t          out_item_r;
  out_item_t          out_item_nxt;

  logic take1, take2, take3, take4;
  logic in_fire, emit;
  logic signed [33:0] x_gap;
  logic signed [32:0] d_hi, d_lo;
  logic [32:0]        screen_sum;
  logic [55:0]        column_prod;
  logic [ROW_CLIP_W-1:0] row_bottom;

  function automatic logic signed [31:0] row_calc(input logic neg, input logic [63:0] prod,
                                                  input logic [PANE_W-1:0] top);
    logic signed [33:0] r;
    logic               frac;
    frac = |prod[31:0];
    if (!neg) begin
      r = $signed({2'b00, prod[63:32]}) + $signed({22'd0, top});
    end else begin
      r = $signed({22'd0, top}) - $signed({2'b00, prod[63:32]});
      if (frac && (r > 34'sd0)) begin
        r = r - 34'sd1;
      end
    end
    if (r > 34'sh0_7FFF_FFFF) begin
      row_calc = 32'sh7FFF_FFFF;
    end else if (r < -34'sh0_8000_0000) begin
      row_calc = 32'sh8000_0000;
    end else begin
      row_calc = r[31:0];
    end
  endfunction

  function automatic logic [ROW_CLIP_W-1:0] clamp_row(input logic signed [31:0] r,
                                                      input logic [ROW_CLIP_W-1:0] lo,
                                                      input logic [ROW_CLIP_W-1:0] hi);
    if (r < $signed({19'd0, lo})) begin
      clamp_row = lo;
    end else if (r > $signed({19'd0, hi})) begin
      clamp_row = hi;
    end else begin
      clamp_row = r[ROW_CLIP_W-1:0];
    end
  endfunction

  assign take4    = !out_valid_r || out_ready;
  assign take3    = !s3_valid_r || take4;
  assign take2    = !s2_valid_r || take3;
  assign take1    = !s1_valid_r || take2;
  assign in_ready = take1;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign in_fire = in_valid && in_ready;
  assign x_gap   = {{2{in_item.sample_x[31]}}, in_item.sample_x}
                 - {{2{window_start_x_r[31]}}, window_start_x_r};
  assign emit    = in_fire && !in_item.series_start
                 && (x_gap > $signed({3'b000, x_resolution_r}));

  assign d_hi = {reference_y_max_r[31], reference_y_max_r} - {window_max_y_r[31], window_max_y_r};
  assign d_lo = {reference_y_max_r[31], reference_y_max_r} - {window_min_y_r[31], window_min_y_r};
  assign screen_sum = {2'b00, column_pixel_r} + {21'd0, pane_left_r};

  assign column_prod = {32'd0, sample_index_r} * {24'd0, column_step_r};
  always_comb begin
    if (|column_prod[55:47]) begin
      column_pixel_nxt = '1;
    end else begin
      column_pixel_nxt = column_prod[46:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_resolution_r    <= 31'd65536;
      reference_y_max_r <= '0;
      y_scale_r         <= 32'd65536;
      column_step_r     <= 32'd65536;
      pane_left_r       <= '0;
      pane_top_r        <= '0;
      pane_width_r      <= 12'd640;
      pane_height_r     <= 12'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_X_RESOLUTION:    x_resolution_r    <= cfg_data[30:0];
        CFG_REFERENCE_Y_MAX: reference_y_max_r <= cfg_data;
        CFG_Y_SCALE:         y_scale_r         <= cfg_data;
        CFG_COLUMN_STEP:     column_step_r     <= cfg_data;
        CFG_PANE_LEFT:       pane_left_r       <= cfg_data[PANE_W-1:0];
        CFG_PANE_TOP:        pane_top_r        <= cfg_data[PANE_W-1:0];
        CFG_PANE_WIDTH:      pane_width_r      <= cfg_data[PANE_W-1:0];
        CFG_PANE_HEIGHT:     pane_height_r     <= cfg_data[PANE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_start_x_r <= '0;
      window_min_y_r   <= '0;
      window_max_y_r   <= '0;
      sample_index_r   <= '0;
      column_pixel_r   <= '0;
    end else if (in_fire) begin
      if (in_item.series_start) begin
        window_start_x_r <= in_item.sample_x;
        window_min_y_r   <= in_item.sample_y;
        window_max_y_r   <= in_item.sample_y;
        column_pixel_r   <= '0;
        sample_index_r   <= {{(SAMPLE_INDEX_W-1){1'b0}}, 1'b1};
      end else begin
        if (emit) begin
          window_start_x_r <= in_item.sample_x;
          window_min_y_r   <= in_item.sample_y;
          window_max_y_r   <= in_item.sample_y;
          column_pixel_r   <= column_pixel_nxt;
        end else begin
          if (in_item.sample_y < window_min_y_r) begin
            window_min_y_r <= in_item.sample_y;
          end
          if (in_item.sample_y > window_max_y_r) begin
            window_max_y_r <= in_item.sample_y;
          end
        end
        if (sample_index_r != INDEX_LAST) begin
          sample_index_r <= sample_index_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take1) begin
        s1_valid_r <= emit;
      end
      if (take2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (take3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (take4) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take1 && emit) begin
      s1_neg_hi_r <= d_hi[32];
      s1_neg_lo_r <= d_lo[32];
      s1_mag_hi_r <= d_hi[32] ? 32'(-d_hi) : d_hi[31:0];
      s1_mag_lo_r <= d_lo[32] ? 32'(-d_lo) : d_lo[31:0];
      s1_screen_r <= screen_sum[31] ? 32'sh7FFF_FFFF : $signed(screen_sum[31:0]);
      s1_col_ok_r <= {1'b0, column_pixel_r} <= {20'd0, pane_width_r};
    end
    if (take2 && s1_valid_r) begin
      s2_neg_hi_r  <= s1_neg_hi_r;
      s2_neg_lo_r  <= s1_neg_lo_r;
      s2_prod_hi_r <= s1_mag_hi_r * y_scale_r;
      s2_prod_lo_r <= s1_mag_lo_r * y_scale_r;
      s2_screen_r  <= s1_screen_r;
      s2_col_ok_r  <= s1_col_ok_r;
    end
    if (take3 && s2_valid_r) begin
      s3_row_from_r <= row_calc(s2_neg_hi_r, s2_prod_hi_r, pane_top_r);
      s3_row_to_r   <= row_calc(s2_neg_lo_r, s2_prod_lo_r, pane_top_r);
      s3_screen_r   <= s2_screen_r;
      s3_col_ok_r   <= s2_col_ok_r;
    end
    if (take4 && s3_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_comb begin
    logic signed [33:0] rows;
    logic               rows_pos;
    row_bottom = {1'b0, pane_top_r} + {1'b0, pane_height_r};
    rows_pos   = s3_row_to_r >= s3_row_from_r;
    rows       = {{2{s3_row_to_r[31]}}, s3_row_to_r} - {{2{s3_row_from_r[31]}}, s3_row_from_r}
               + 34'sd1;
    out_item_nxt.screen_column  = s3_screen_r;
    out_item_nxt.row_from       = s3_row_from_r;
    out_item_nxt.row_to         = s3_row_to_r;
    out_item_nxt.clipped_top    = clamp_row(s3_row_from_r, {1'b0, pane_top_r}, row_bottom);
    out_item_nxt.clipped_bottom = clamp_row(s3_row_to_r, {1'b0, pane_top_r}, row_bottom);
    out_item_nxt.has_visible    = 1'b0;
    out_item_nxt.out_of_bounds  = 1'b0;
    out_item_nxt.span_rows      = '0;
    if (rows_pos) begin
      out_item_nxt.span_rows = rows[32] ? 32'hFFFF_FFFF : rows[31:0];
      if (s3_col_ok_r) begin
        out_item_nxt.has_visible   = (s3_row_from_r <= $signed({19'd0, row_bottom}))
                                  && (s3_row_to_r >= $signed({20'd0, pane_top_r}));
        out_item_nxt.out_of_bounds = (s3_row_from_r < $signed({20'd0, pane_top_r}))
                                  || (s3_row_to_r > $signed({19'd0, row_bottom}));
      end else begin
        out_item_nxt.out_of_bounds = 1'b1;
      end
    end
  end

endmodule

// File: tb/tb_min_max_column_decimator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Min/max column decimator testbench
// Streams (x, y) samples into the decimator, predicts every emitted column
// span from a behavioral copy of the window, row and clip arithmetic, and
// compares each span field by field under several register settings and
// several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_min_max_column_decimator;
  import mmcd_pkg::*;

  localparam longint      S32_MAX      = 64'sd2147483647;
  localparam longint      S32_MIN      = -64'sd2147483648;
  localparam int unsigned SAMPLE_LIMIT = 1 << SAMPLE_INDEX_W;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          RUN_ITEMS    = 92;

  typedef struct {
    logic [30:0]        x_res;
    logic signed [31:0] ref_y;
    logic [31:0]        scale;
    logic [31:0]        step;
    logic [11:0]        left;
    logic [11:0]        top;
    logic [11:0]        width;
    logic [11:0]        height;
  } display_cfg_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  display_cfg_t       cur;
  logic signed [31:0] win_start_x;
  logic signed [31:0] win_min_y;
  logic signed [31:0] win_max_y;
  int unsigned        next_index;
  longint             col_px;
  out_item_t          pending_spans[$];
  out_item_t          want;
  int                 mismatches;
  int                 send_idle_pct;
  int                 recv_stall_pct;

  min_max_column_decimator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic longint sat_s32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint pixel_row(logic signed [31:0] y);
    longint     diff;
    longint     q;
    longint     r;
    logic [63:0] mag;
    logic [63:0] prod;
    diff = longint'(cur.ref_y) - longint'(y);
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = mag * {32'd0, cur.scale};
    q    = longint'({32'd0, prod[63:32]});
    if (diff >= 0) begin
      r = q + longint'(cur.top);
    end else begin
      r = longint'(cur.top) - q;
      if (prod[31:0] != 32'd0 && r > 0) r = r - 1;
    end
    return sat_s32(r);
  endfunction

  function automatic logic [ROW_CLIP_W-1:0] clip_row(longint r, longint lo, longint hi);
    longint v;
    v = r;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v[ROW_CLIP_W-1:0];
  endfunction

  function automatic void advance_window(in_item_t it);
    longint      x_step;
    longint      rf;
    longint      rt;
    longint      top;
    longint      bot;
    longint      rows;
    logic [63:0] cprod;
    int unsigned idx;
    bit          vis;
    bit          oob;
    out_item_t   s;
    if (it.series_start) begin
      win_start_x = it.sample_x;
      win_min_y   = it.sample_y;
      win_max_y   = it.sample_y;
      col_px      = 0;
      next_index  = 1;
      return;
    end
    idx    = next_index;
    x_step = longint'(it.sample_x) - longint'(win_start_x);
    if (x_step > longint'(cur.x_res)) begin
      rf   = pixel_row(win_max_y);
      rt   = pixel_row(win_min_y);
      top  = longint'(cur.top);
      bot  = top + longint'(cur.height);
      rows = (rt >= rf) ? rt - rf + 1 : 0;
      vis  = 1'b0;
      oob  = 1'b0;
      if (rows > 0) begin
        if (col_px <= longint'(cur.width)) begin
          vis = (rf <= bot) && (rt >= top);
          oob = (rf < top) || (rt > bot);
        end else begin
          oob = 1'b1;
        end
      end
      if (rows > 64'sh0_FFFF_FFFF) rows = 64'sh0_FFFF_FFFF;
      s.screen_column  = 32'(sat_s32(col_px + longint'(cur.left)));
      s.row_from       = 32'(rf);
      s.row_to         = 32'(rt);
      s.clipped_top    = clip_row(rf, top, bot);
      s.clipped_bottom = clip_row(rt, top, bot);
      s.has_visible    = vis;
      s.out_of_bounds  = oob;
      s.span_rows      = rows[31:0];
      pending_spans    = {pending_spans, s};
      win_start_x = it.sample_x;
      win_min_y   = it.sample_y;
      win_max_y   = it.sample_y;
      cprod       = 64'(idx) * 64'(cur.step);
      cprod       = cprod >> 16;
      col_px      = (cprod > 64'(S32_MAX)) ? S32_MAX : longint'(cprod);
    end else begin
      if (it.sample_y < win_min_y) win_min_y = it.sample_y;
      if (it.sample_y > win_max_y) win_max_y = it.sample_y;
    end
    next_index = (idx < SAMPLE_LIMIT - 1) ? idx + 1 : SAMPLE_LIMIT - 1;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %08h, got %08h", what, exp_val, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected span item at screen column %0d", out_item.screen_column);
        end
      end else begin
        want = pending_spans.pop_front();
        if (out_item.screen_column !== want.screen_column)
          note_mismatch("screen_column", out_item.screen_column, want.screen_column);
        if (out_item.row_from !== want.row_from)
          note_mismatch("row_from", out_item.row_from, want.row_from);
        if (out_item.row_to !== want.row_to)
          note_mismatch("row_to", out_item.row_to, want.row_to);
        if (out_item.clipped_top !== want.clipped_top)
          note_mismatch("clipped_top", 32'(out_item.clipped_top), 32'(want.clipped_top));
        if (out_item.clipped_bottom !== want.clipped_bottom)
          note_mismatch("clipped_bottom", 32'(out_item.clipped_bottom),
                        32'(want.clipped_bottom));
        if (out_item.has_visible !== want.has_visible)
          note_mismatch("has_visible", 32'(out_item.has_visible), 32'(want.has_visible));
        if (out_item.out_of_bounds !== want.out_of_bounds)
          note_mismatch("out_of_bounds", 32'(out_item.out_of_bounds),
                        32'(want.out_of_bounds));
        if (out_item.span_rows !== want.span_rows)
          note_mismatch("span_rows", out_item.span_rows, want.span_rows);
      end
    end
  end

  task automatic push_sample(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic start);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.sample_x     = x;
    it.sample_y     = y;
    it.series_start = start;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_window(it);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Unused upper bits carry random values; the block must ignore them.
  task automatic apply_setting(input display_cfg_t s);
    write_reg(CFG_X_RESOLUTION, {1'($urandom_range(1)), s.x_res});
    write_reg(CFG_REFERENCE_Y_MAX, s.ref_y);
    write_reg(CFG_Y_SCALE, s.scale);
    write_reg(CFG_COLUMN_STEP, s.step);
    write_reg(CFG_PANE_LEFT, {20'($urandom), s.left});
    write_reg(CFG_PANE_TOP, {20'($urandom), s.top});
    write_reg(CFG_PANE_WIDTH, {20'($urandom), s.width});
    write_reg(CFG_PANE_HEIGHT, {20'($urandom), s.height});
    cfg_valid <= 1'b0;
    cur = s;
  endtask

  function automatic display_cfg_t random_display_cfg(bit wild);
    display_cfg_t s;
    s.x_res  = 31'($urandom_range(1 << 10, 1 << 18));
    s.left   = 12'($urandom);
    s.width  = 12'($urandom_range(1, 800));
    s.height = 12'($urandom_range(1, 500));
    s.top    = 12'($urandom_range(0, 600));
    s.ref_y  = $urandom_range(0, 4000 << 16) - (2000 << 16);
    s.scale  = ($urandom_range(1, 16) << 16) | $urandom_range(0, 65535);
    s.step   = $urandom_range(0, 8 << 16);
    if (wild) begin
      s.x_res  = 31'($urandom_range(0, 1 << 20));
      s.ref_y  = $urandom;
      s.scale  = $urandom;
      s.step   = $urandom;
      s.top    = 12'($urandom);
      s.width  = 12'($urandom_range(1, 4095));
      s.height = 12'($urandom_range(1, 4095));
    end
    return s;
  endfunction

  // Most y values land near the pane so that spans straddle its edges.
  function automatic logic signed [31:0] pick_y(bit wild);
    int k;
    int reach;
    k = int'(cur.scale[31:16]);
    if (k == 0 || (wild && $urandom_range(1) == 1)) return $urandom;
    reach = ((int'(cur.height) + 100) << 16) / k;
    return cur.ref_y - ($urandom_range(0, reach) - reach / 5);
  endfunction

  task automatic test_open_window_after_reset();
    push_sample(32'sh0000_8000, 32'sh0003_0000, 1'b0);
    push_sample(32'sh0001_0000, -32'sh0002_0000, 1'b0);
    push_sample(32'sh0001_0001, 32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    push_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    push_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    push_sample(32'sh7FFF_FFFF, 32'sh0000_0000, 1'b1);
    push_sample(32'sh7FFF_FFFF, 32'sh0000_0005, 1'b0);
    push_sample(32'sh8000_0000, 32'shFFFF_FFFF, 1'b0);
    wait_until_drained();
  endtask

  task automatic test_register_extremes();
    display_cfg_t s;
    s = '{x_res: 31'd0, ref_y: 32'sh8000_0000, scale: 32'hFFFF_FFFF, step: 32'hFFFF_FFFF,
          left: 12'hFFF, top: 12'hFFF, width: 12'd1, height: 12'd1};
    apply_setting(s);
    push_sample(32'sd0, 32'sh7FFF_FFFF, 1'b1);
    push_sample(32'sd0, 32'sh8000_0000, 1'b0);
    push_sample(32'sd1, 32'sd0, 1'b0);
    push_sample(32'sd2, 32'sh8000_0000, 1'b0);
    push_sample(32'sd3, -32'sd1, 1'b0);
    push_sample(32'sd4, 32'sh7FFF_FFFF, 1'b0);
    wait_until_drained();
    s = '{x_res: 31'h7FFF_FFFF, ref_y: 32'sh7FFF_FFFF, scale: 32'd0, step: 32'd0,
          left: 12'd0, top: 12'd0, width: 12'hFFF, height: 12'hFFF};
    apply_setting(s);
    push_sample(32'sh8000_0000, -32'sd1, 1'b1);
    push_sample(32'sh7FFF_FFFF, 32'sd0, 1'b0);
    push_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    wait_until_drained();
  endtask

  task automatic test_decimation(input int send_pct, input int stall_pct, input bit wild,
                                 input bit hold_midway);
    int sent;
    int len;
    int x;
    int res;
    bit held;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int round = 0; round < 2; round++) begin
      apply_setting(random_display_cfg(wild && round == 1));
      sent = 0;
      held = 1'b0;
      res  = int'(cur.x_res);
      while (sent < RUN_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          push_sample($urandom, $urandom, 1'($urandom_range(1)));
          sent++;
        end else begin
          len = $urandom_range(4, 40);
          x   = -int'($urandom_range(0, 1 << 30));
          push_sample(x, pick_y(wild), 1'b1);
          sent++;
          for (int k = 0; k < len; k++) begin
            x = x + int'($urandom_range(res / 4, res + res / 2));
            push_sample(x, pick_y(wild), 1'b0);
            sent++;
          end
        end
        if (hold_midway && !held && sent >= RUN_ITEMS / 2) begin
          wait_until_drained();
          held = 1'b1;
        end
      end
      wait_until_drained();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur = '{x_res: 31'd65536, ref_y: 32'sd0, scale: 32'd65536, step: 32'd65536,
            left: 12'd0, top: 12'd0, width: 12'd640, height: 12'd480};
    win_start_x = '0;
    win_min_y   = '0;
    win_max_y   = '0;
    next_index  = 0;
    col_px      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_open_window_after_reset();
    test_register_extremes();
    test_decimation(0, 0, 1'b0, 1'b1);
    test_decimation(67, 0, 1'b0, 1'b0);
    test_decimation(0, 67, 1'b1, 1'b0);
    test_decimation(26, 26, 1'b1, 1'b1);

    if (mismatches == 0 && pending_spans.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
